// ----- src/tbdc_pkg.sv -----
package tbdc_pkg;

  // Width of the count fields and the state field on the result word.
  localparam int unsigned OutCntW = 16;
  localparam int unsigned TrkW    = 3;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned RunW    = 9;

  // Debounce limit after reset.
  localparam logic [LimitW-1:0] DEBOUNCE_RESET = 8'd5;

  // Run counter saturation value.
  localparam logic [RunW-1:0] RUN_MAX = 9'd511;

  // Direction tracker state codes.
  localparam logic [TrkW-1:0] TRK_START      = 3'd0;
  localparam logic [TrkW-1:0] TRK_CLEAR      = 3'd1;
  localparam logic [TrkW-1:0] TRK_B1_CUT     = 3'd2;
  localparam logic [TrkW-1:0] TRK_B2_CUT     = 3'd3;
  localparam logic [TrkW-1:0] TRK_BOTH_AFT1  = 3'd4;
  localparam logic [TrkW-1:0] TRK_BOTH_AFT2  = 3'd5;
  localparam logic [TrkW-1:0] TRK_ENTERING   = 3'd6;
  localparam logic [TrkW-1:0] TRK_EXITING    = 3'd7;

  // Debounced status of one beam.
  typedef struct packed {
    logic level;
    logic known;
  } beam_t;

endpackage

// ----- src/tbdc_in_if.sv -----
interface tbdc_in_if;
  logic valid;
  logic ready;
  logic beam1_raw;
  logic beam2_raw;

  modport source (output valid, output beam1_raw, output beam2_raw, input ready);
  modport sink (input valid, input beam1_raw, input beam2_raw, output ready);
endinterface

// ----- src/tbdc_out_if.sv -----
interface tbdc_out_if;
  import tbdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OutCntW-1:0] beam1_breaks;
  logic [OutCntW-1:0] beam2_breaks;
  logic [OutCntW-1:0] entered_count;
  logic [OutCntW-1:0] exited_count;
  logic               beam1_level;
  logic               beam2_level;
  logic               levels_valid;
  logic [TrkW-1:0]    tracker_state;

  modport source (
    output valid, output beam1_breaks, output beam2_breaks, output entered_count,
    output exited_count, output beam1_level, output beam2_level,
    output levels_valid, output tracker_state, input ready
  );
  modport sink (
    input valid, input beam1_breaks, input beam2_breaks, input entered_count,
    input exited_count, input beam1_level, input beam2_level,
    input levels_valid, input tracker_state, output ready
  );
endinterface

// ----- src/tbdc_cfg_if.sv -----
interface tbdc_cfg_if;
  import tbdc_pkg::*;

  logic              valid;
  logic              ready;
  logic [LimitW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/tbdc_debounce.sv -----
module tbdc_debounce (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        raw_i,
  input  logic [tbdc_pkg::LimitW-1:0] limit_i,
  output tbdc_pkg::beam_t             beam_d_o,
  output tbdc_pkg::beam_t             beam_q_o
);
  import tbdc_pkg::*;

  logic            cand_q, cand_d;
  logic [RunW-1:0] run_q, run_d;
  logic            stable_q, stable_d;
  logic            known_q, known_d;

  // Restart the run on a new level, else count it up to saturation.
  // The level is taken once the run exceeds the limit.
  always_comb begin
    cand_d   = cand_q;
    run_d    = run_q;
    stable_d = stable_q;
    known_d  = known_q;
    if ((run_q == '0) || (raw_i != cand_q)) begin
      cand_d = raw_i;
      run_d  = RunW'(1);
    end else if (run_q != RUN_MAX) begin
      run_d = run_q + RunW'(1);
    end
    if (run_d > {1'b0, limit_i}) begin
      stable_d = cand_d;
      known_d  = 1'b1;
    end
  end

  // State advances only on an accepted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q   <= 1'b0;
      run_q    <= '0;
      stable_q <= 1'b0;
      known_q  <= 1'b0;
    end else if (en_i) begin
      cand_q   <= cand_d;
      run_q    <= run_d;
      stable_q <= stable_d;
      known_q  <= known_d;
    end
  end

  assign beam_d_o.level = stable_d & known_d;
  assign beam_d_o.known = known_d;
  assign beam_q_o.level = stable_q & known_q;
  assign beam_q_o.known = known_q;

endmodule

// ----- src/two_beam_direction_counter.sv -----
// Two-beam direction counter. Each input word carries one raw sample of both
// light beams (1 means light reaches the diode). Each beam is debounced: a
// level is taken once it has been seen for debounce_limit+1 samples in a row
// (debounce_limit resets to 5; the user writes it through the configuration
// port only while the block is idle, which the block does not enforce). When
// both levels are known, a direction tracker counts breaks of each beam and
// objects entering (beam one cut first) or exiting (beam two cut first); all
// counters saturate at 2^COUNT_WIDTH-1 and show their low 16 bits. Every input
// word produces one result word. The block takes one word per clock unless a
// pending result stalls: the debouncers, the tracker and the counter updates
// sit in one stage, and the updated state registers form the result register,
// so a new word is accepted in the same cycle the previous result is taken.
module two_beam_direction_counter #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tbdc_cfg_if.sink          cfg_i,
  tbdc_in_if.sink           in_i,
  tbdc_out_if.source        out_o
);
  import tbdc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  logic                   out_valid_q;
  logic                   in_acc;
  logic [LimitW-1:0]      limit_q;
  beam_t                  beam1_d, beam1_q, beam2_d, beam2_q;
  logic                   both_known;
  logic [TrkW-1:0]        trk_q, trk_d;
  logic [COUNT_WIDTH-1:0] brk1_q, brk2_q, ent_q, ext_q;
  logic                   inc_brk1, inc_brk2, inc_ent, inc_ext;
  logic [COUNT_WIDTH+OutCntW-1:0] brk1_ext, brk2_ext, ent_ext, ext_ext;

  // Handshake: a word is taken whenever the result register is free or drains.
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // Debounce limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DEBOUNCE_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data;
    end
  end

  tbdc_debounce u_deb1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (in_acc),
    .raw_i    (in_i.beam1_raw),
    .limit_i  (limit_q),
    .beam_d_o (beam1_d),
    .beam_q_o (beam1_q)
  );

  tbdc_debounce u_deb2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (in_acc),
    .raw_i    (in_i.beam2_raw),
    .limit_i  (limit_q),
    .beam_d_o (beam2_d),
    .beam_q_o (beam2_q)
  );

  assign both_known = beam1_d.known && beam2_d.known;

  // Direction tracker on this sample's debounced levels.
  always_comb begin
    trk_d    = trk_q;
    inc_brk1 = 1'b0;
    inc_brk2 = 1'b0;
    inc_ent  = 1'b0;
    inc_ext  = 1'b0;
    if (both_known) begin
      case (trk_q)
        TRK_START: begin
          if (beam1_d.level && beam2_d.level) trk_d = TRK_CLEAR;
        end
        TRK_CLEAR: begin
          if (!beam1_d.level) begin
            trk_d    = TRK_B1_CUT;
            inc_brk1 = 1'b1;
          end else if (!beam2_d.level) begin
            trk_d    = TRK_B2_CUT;
            inc_brk2 = 1'b1;
          end
        end
        TRK_B1_CUT: begin
          if (beam1_d.level) begin
            trk_d = TRK_CLEAR;
          end else if (!beam2_d.level) begin
            trk_d    = TRK_BOTH_AFT1;
            inc_brk2 = 1'b1;
          end
        end
        TRK_B2_CUT: begin
          if (beam2_d.level) begin
            trk_d = TRK_CLEAR;
          end else if (!beam1_d.level) begin
            trk_d    = TRK_BOTH_AFT2;
            inc_brk1 = 1'b1;
          end
        end
        TRK_BOTH_AFT1: begin
          if (beam1_d.level && !beam2_d.level) trk_d = TRK_ENTERING;
          else if (!beam1_d.level && beam2_d.level) trk_d = TRK_B1_CUT;
        end
        TRK_BOTH_AFT2: begin
          if (!beam1_d.level && beam2_d.level) trk_d = TRK_EXITING;
          else if (beam1_d.level && !beam2_d.level) trk_d = TRK_B2_CUT;
        end
        TRK_ENTERING: begin
          if (beam1_d.level && beam2_d.level) begin
            trk_d   = TRK_CLEAR;
            inc_ent = 1'b1;
          end else if (!beam1_d.level && !beam2_d.level) begin
            trk_d    = TRK_BOTH_AFT1;
            inc_brk1 = 1'b1;
          end
        end
        TRK_EXITING: begin
          if (beam1_d.level && beam2_d.level) begin
            trk_d   = TRK_CLEAR;
            inc_ext = 1'b1;
          end else if (!beam1_d.level && !beam2_d.level) begin
            trk_d    = TRK_BOTH_AFT2;
            inc_brk2 = 1'b1;
          end
        end
        default: trk_d = TRK_START;
      endcase
    end
  end

  // Tracker state and saturating counters; these double as the result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q  <= TRK_START;
      brk1_q <= '0;
      brk2_q <= '0;
      ent_q  <= '0;
      ext_q  <= '0;
    end else if (in_acc) begin
      trk_q <= trk_d;
      if (inc_brk1 && (brk1_q != CntMax)) brk1_q <= brk1_q + COUNT_WIDTH'(1);
      if (inc_brk2 && (brk2_q != CntMax)) brk2_q <= brk2_q + COUNT_WIDTH'(1);
      if (inc_ent && (ent_q != CntMax)) ent_q <= ent_q + COUNT_WIDTH'(1);
      if (inc_ext && (ext_q != CntMax)) ext_q <= ext_q + COUNT_WIDTH'(1);
    end
  end

  // Counters show their low 16 bits, zero-extended when narrower.
  assign brk1_ext = {{OutCntW{1'b0}}, brk1_q};
  assign brk2_ext = {{OutCntW{1'b0}}, brk2_q};
  assign ent_ext  = {{OutCntW{1'b0}}, ent_q};
  assign ext_ext  = {{OutCntW{1'b0}}, ext_q};

  assign out_o.valid         = out_valid_q;
  assign out_o.beam1_breaks  = brk1_ext[OutCntW-1:0];
  assign out_o.beam2_breaks  = brk2_ext[OutCntW-1:0];
  assign out_o.entered_count = ent_ext[OutCntW-1:0];
  assign out_o.exited_count  = ext_ext[OutCntW-1:0];
  assign out_o.beam1_level   = beam1_q.level;
  assign out_o.beam2_level   = beam2_q.level;
  assign out_o.levels_valid  = beam1_q.known && beam2_q.known;
  assign out_o.tracker_state = trk_q;

endmodule

// ----- src/tbdc_checker.sv -----
module tbdc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [tbdc_pkg::OutCntW-1:0] beam1_breaks_i,
  input logic [tbdc_pkg::OutCntW-1:0] beam2_breaks_i,
  input logic [tbdc_pkg::OutCntW-1:0] entered_count_i,
  input logic [tbdc_pkg::OutCntW-1:0] exited_count_i,
  input logic                         levels_valid_i,
  input logic [tbdc_pkg::TrkW-1:0]    tracker_state_i
);
  import tbdc_pkg::*;

  // A pending result word is held until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // An empty result register never blocks the input.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // Every accepted word yields a result word in the next cycle.
  a_one_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("result word missing after accepted word");

  // Before both levels are known the tracker is idle and nothing is counted.
  a_idle_until_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !levels_valid_i |-> (tracker_state_i == TRK_START) &&
      (beam1_breaks_i == '0) && (beam2_breaks_i == '0) &&
      (entered_count_i == '0) && (exited_count_i == '0))
    else $error("tracker active before both levels known");

  // Once both levels are known they stay known.
  a_known_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && levels_valid_i |=> !out_valid_i || levels_valid_i)
    else $error("levels_valid fell");

endmodule

bind two_beam_direction_counter tbdc_checker u_tbdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .beam1_breaks_i  (out_o.beam1_breaks),
  .beam2_breaks_i  (out_o.beam2_breaks),
  .entered_count_i (out_o.entered_count),
  .exited_count_i  (out_o.exited_count),
  .levels_valid_i  (out_o.levels_valid),
  .tracker_state_i (out_o.tracker_state)
);
